### src/gm3_pkg.sv
// Package for the 3x3 gradient magnitude block: lane handshake structs,
// fixed datapath widths, register indexes, default kernel packing and saturation.
// No dependencies.
package gm3_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int N_CH       = 3;
    localparam int TAPS       = 9;
    localparam int TAP_IW     = 4;
    localparam int GM_W       = 9;
    localparam int SQ_W       = 2 * GM_W;
    localparam int NS_W       = SQ_W + 1;
    localparam int ROOT_W     = 10;
    localparam int SQRT_STEPS = 10;
    localparam int PK_W       = 63;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_KERNEL_X     = 2'd2,
        REG_KERNEL_Y     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic start;
    } lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_sts_t;

    // Sobel kernels, entry row*3+col, row 0 newest, col 0 oldest
    function automatic logic [PK_W-1:0] sobel_pack(input int cbits, input logic is_y);
        logic [PK_W-1:0] res;
        logic [PK_W-1:0] mask;
        int v;
        res  = '0;
        mask = (PK_W'(1) << cbits) - PK_W'(1);
        for (int k = 0; k < TAPS; k++) begin
            if (is_y) begin
                case (k)
                    0, 2:    v = -1;
                    1:       v = -2;
                    6, 8:    v = 1;
                    7:       v = 2;
                    default: v = 0;
                endcase
            end else begin
                case (k)
                    0, 6:    v = -1;
                    3:       v = -2;
                    2, 8:    v = 1;
                    5:       v = 2;
                    default: v = 0;
                endcase
            end
            res = res | ((PK_W'(v) & mask) << (cbits * k));
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] sat8(input logic [ROOT_W-1:0] r);
        return (r > ROOT_W'(255)) ? {PIX_W{1'b1}} : r[PIX_W-1:0];
    endfunction

endpackage

### src/gm3_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gm3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/gm3_lane.sv
// One channel lane: serial 9-tap MAC for both kernels, restoring floor
// dividers, squares and a digit-by-digit square root. Uses gm3_pkg.
module gm3_lane #(
    parameter int COEF_BITS = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gm3_pkg::lane_ctl_t        ctl,
    output gm3_pkg::lane_sts_t        sts,
    input  logic [gm3_pkg::PIX_W-1:0] taps [gm3_pkg::TAPS],
    input  logic [9*COEF_BITS-1:0]    kernel_x,
    input  logic [9*COEF_BITS-1:0]    kernel_y,
    output logic [gm3_pkg::ROOT_W-1:0] root
);
    import gm3_pkg::*;

    localparam int KW     = 9 * COEF_BITS;
    localparam int MAXK   = 9 * (2 ** (COEF_BITS - 1));
    localparam int SUM_W  = $clog2(MAXK * 255 + 1) + 1;
    localparam int UW     = SUM_W - 1;
    localparam int DIV_W  = $clog2(MAXK + 1);
    localparam int PROD_W = COEF_BITS + PIX_W + 1;
    localparam int CNT_W  = $clog2(UW + 1);

    typedef enum logic [6:0] {
        L_IDLE = 7'b0000001,
        L_MAC  = 7'b0000010,
        L_DIV  = 7'b0000100,
        L_SQ   = 7'b0001000,
        L_ADD  = 7'b0010000,
        L_SQRT = 7'b0100000,
        L_DONE = 7'b1000000
    } lstate_t;

    lstate_t           state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic signed [SUM_W-1:0] acc_reg  [2];
    logic [DIV_W-1:0]        dsum_reg [2];
    logic [UW-1:0]           dvd_reg  [2];
    logic [DIV_W-1:0]        rem_reg  [2];
    logic [UW-1:0]           quo_reg  [2];
    logic                    neg_reg  [2];
    logic [SQ_W-1:0]         sq_reg   [2];
    logic [NS_W-1:0]         nrem_reg, root_reg, bit_reg;

    logic [KW-1:0]              kern   [2];
    logic [TAP_IW-1:0]          tidx;
    logic [PIX_W-1:0]           pix;
    logic signed [COEF_BITS-1:0] coef  [2];
    logic [COEF_BITS-1:0]       cabs   [2];
    logic signed [PROD_W-1:0]   prod   [2];
    logic signed [SUM_W-1:0]    acc_nx [2];
    logic [DIV_W:0]             sh     [2];
    logic                       ge     [2];
    logic [GM_W-1:0]            gm     [2];
    logic [NS_W-1:0]            trial;

    assign kern[0] = kernel_x;
    assign kern[1] = kernel_y;
    assign tidx    = cnt_reg[TAP_IW-1:0];
    assign pix     = taps[tidx];
    assign trial   = root_reg + bit_reg;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            coef[i]   = signed'(kern[i][COEF_BITS*tidx +: COEF_BITS]);
            cabs[i]   = coef[i][COEF_BITS-1] ? COEF_BITS'(-coef[i]) : COEF_BITS'(coef[i]);
            prod[i]   = PROD_W'(coef[i]) * PROD_W'(signed'({1'b0, pix}));
            acc_nx[i] = acc_reg[i] + SUM_W'(prod[i]);
            sh[i]     = {rem_reg[i], dvd_reg[i][UW-1]};
            ge[i]     = sh[i] >= {1'b0, dsum_reg[i]};
            if (dsum_reg[i] == '0) begin
                gm[i] = '0;
            end else begin
                gm[i] = quo_reg[i][GM_W-1:0]
                      + GM_W'(neg_reg[i] && (rem_reg[i] != '0));
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            L_IDLE, L_DONE: begin
                if (ctl.start) begin
                    state_next = L_MAC;
                    cnt_next   = '0;
                end
            end
            L_MAC: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TAPS - 1)) begin
                    state_next = L_DIV;
                    cnt_next   = '0;
                end
            end
            L_DIV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(UW - 1)) begin
                    state_next = L_SQ;
                    cnt_next   = '0;
                end
            end
            L_SQ: begin
                state_next = L_ADD;
            end
            L_ADD: begin
                state_next = L_SQRT;
                cnt_next   = '0;
            end
            L_SQRT: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = L_DONE;
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            L_IDLE, L_DONE: begin
                for (int i = 0; i < 2; i++) begin
                    acc_reg[i]  <= '0;
                    dsum_reg[i] <= '0;
                end
            end
            L_MAC: begin
                for (int i = 0; i < 2; i++) begin
                    acc_reg[i]  <= acc_nx[i];
                    dsum_reg[i] <= dsum_reg[i] + DIV_W'(cabs[i]);
                    dvd_reg[i]  <= acc_nx[i][SUM_W-1] ? UW'(-acc_nx[i]) : UW'(acc_nx[i]);
                    neg_reg[i]  <= acc_nx[i][SUM_W-1];
                    rem_reg[i]  <= '0;
                    quo_reg[i]  <= '0;
                end
            end
            L_DIV: begin
                for (int i = 0; i < 2; i++) begin
                    rem_reg[i] <= ge[i] ? DIV_W'(sh[i] - {1'b0, dsum_reg[i]})
                                        : DIV_W'(sh[i]);
                    quo_reg[i] <= {quo_reg[i][UW-2:0], ge[i]};
                    dvd_reg[i] <= {dvd_reg[i][UW-2:0], 1'b0};
                end
            end
            L_SQ: begin
                for (int i = 0; i < 2; i++) begin
                    sq_reg[i] <= SQ_W'(gm[i]) * SQ_W'(gm[i]);
                end
            end
            L_ADD: begin
                nrem_reg <= NS_W'(sq_reg[0]) + NS_W'(sq_reg[1]);
                root_reg <= '0;
                bit_reg  <= NS_W'(1) << (NS_W - 1);
            end
            L_SQRT: begin
                if (nrem_reg >= trial) begin
                    nrem_reg <= nrem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default: begin
            end
        endcase
    end

    assign sts.busy = (state_reg != L_IDLE) && (state_reg != L_DONE);
    assign sts.done = (state_reg == L_DONE);
    assign root     = root_reg[ROOT_W-1:0];

endmodule

### src/gradient_magnitude_3x3_top.sv
// Top level of the 3x3 gradient magnitude block: row store, window,
// three channel lanes and the merging output register.
// Uses gm3_pkg, gm3_ram, gm3_lane.
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    s_red_in, s_green_in, s_blue_in
//  m_*          out  m_valid/m_ready    m_red_mag, m_green_mag, m_blue_mag, m_frame_end
//  cfg_*        in   cfg_we             cfg_index, cfg_wdata
//
// Border pixels go through accept, row store read and window update only.
// Interior pixels then also run the serial MAC, restoring dividers and square
// root in each lane. One pixel is in work at a time; a result may wait in the
// output register while the next pixel is taken. Synchronous active-low reset;
// row stores are not cleared.
module gradient_magnitude_3x3_top #(
    parameter int MAX_WIDTH = 2048,
    parameter int COEF_BITS = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [gm3_pkg::PIX_W-1:0]  s_red_in,
    input  logic [gm3_pkg::PIX_W-1:0]  s_green_in,
    input  logic [gm3_pkg::PIX_W-1:0]  s_blue_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [gm3_pkg::PIX_W-1:0]  m_red_mag,
    output logic [gm3_pkg::PIX_W-1:0]  m_green_mag,
    output logic [gm3_pkg::PIX_W-1:0]  m_blue_mag,
    output logic                       m_frame_end,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [9*COEF_BITS-1:0]     cfg_wdata
);
    import gm3_pkg::*;

    localparam int KW  = 9 * COEF_BITS;
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WCW = (AW + 1 > 12) ? AW + 1 : 12;
    localparam logic [KW-1:0] KX_RESET = KW'(sobel_pack(COEF_BITS, 1'b0));
    localparam logic [KW-1:0] KY_RESET = KW'(sobel_pack(COEF_BITS, 1'b1));

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_CALC = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [11:0]       width_reg;
    logic [15:0]       height_reg;
    logic [KW-1:0]     kernel_x_reg, kernel_y_reg;
    logic [AW-1:0]     col_reg;
    logic [15:0]       row_reg;
    logic [RGB_W-1:0]  wc0_reg [3];
    logic [RGB_W-1:0]  wc1_reg [3];
    logic [RGB_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  tap_reg [N_CH][TAPS];
    logic              fend_reg;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  mag_reg [N_CH];
    logic              m_fend_reg;

    logic [WCW-1:0]     wclamp;
    logic [15:0]        hclamp;
    logic [AW-1:0]      last_col;
    logic [15:0]        last_row;
    logic [2*RGB_W-1:0] ram_rdata;
    logic [RGB_W-1:0]   newcol [3];
    logic               s_xfer, produce, out_free, all_done, merge;
    lane_ctl_t          lane_ctl;
    lane_sts_t          lane_sts [N_CH];
    logic [ROOT_W-1:0]  lane_root [N_CH];
    logic [N_CH-1:0]    lane_done, lane_busy;

    always_comb begin
        wclamp = WCW'(width_reg);
        if (wclamp < WCW'(3)) begin
            wclamp = WCW'(3);
        end else if (wclamp > WCW'(MAX_WIDTH)) begin
            wclamp = WCW'(MAX_WIDTH);
        end
        hclamp = (height_reg < 16'd3) ? 16'd3 : height_reg;
    end

    assign last_col  = AW'(wclamp - WCW'(1));
    assign last_row  = hclamp - 16'd1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign newcol[0] = ram_rdata[2*RGB_W-1:RGB_W];
    assign newcol[1] = ram_rdata[RGB_W-1:0];
    assign newcol[2] = pix_reg;
    assign produce   = (row_reg >= 16'd2) && (col_reg >= AW'(2));
    assign out_free  = !m_valid_reg || m_ready;
    assign all_done  = &lane_done;
    assign merge     = (state_reg == ST_CALC) && all_done && out_free;
    assign lane_ctl.start = (state_reg == ST_LOAD) && produce;

    gm3_ram #(
        .WIDTH (2 * RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (state_reg == ST_LOAD),
        .waddr (col_reg),
        .wdata ({newcol[1], newcol[2]}),
        .re    (s_xfer),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    for (genvar ch = 0; ch < N_CH; ch++) begin : g_lane
        gm3_lane #(
            .COEF_BITS (COEF_BITS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (lane_ctl),
            .sts      (lane_sts[ch]),
            .taps     (tap_reg[ch]),
            .kernel_x (kernel_x_reg),
            .kernel_y (kernel_y_reg),
            .root     (lane_root[ch])
        );
        assign lane_done[ch] = lane_sts[ch].done;
        assign lane_busy[ch] = lane_sts[ch].busy;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = produce ? ST_CALC : ST_IDLE;
            end
            ST_CALC: begin
                if (merge) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            width_reg    <= 12'd640;
            height_reg   <= 16'd480;
            kernel_x_reg <= KX_RESET;
            kernel_y_reg <= KY_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                wc0_reg[k] <= '0;
                wc1_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg    <= cfg_wdata[11:0];
                    REG_IMAGE_HEIGHT: height_reg   <= cfg_wdata[15:0];
                    REG_KERNEL_X:     kernel_x_reg <= cfg_wdata;
                    REG_KERNEL_Y:     kernel_y_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_LOAD) begin
                for (int k = 0; k < 3; k++) begin
                    wc0_reg[k] <= wc1_reg[k];
                    wc1_reg[k] <= newcol[k];
                end
                if (col_reg >= last_col) begin
                    col_reg <= '0;
                    row_reg <= (row_reg >= last_row) ? 16'd0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_reg + AW'(1);
                end
            end
            if (merge) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window taps: kernel row 0 is the newest row, column 0 the oldest
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pix_reg <= {s_blue_in, s_green_in, s_red_in};
        end
        if (state_reg == ST_LOAD) begin
            fend_reg <= (row_reg == last_row) && (col_reg == last_col);
            for (int ch = 0; ch < N_CH; ch++) begin
                for (int r = 0; r < 3; r++) begin
                    tap_reg[ch][r*3]   <= wc0_reg[2-r][ch*PIX_W +: PIX_W];
                    tap_reg[ch][r*3+1] <= wc1_reg[2-r][ch*PIX_W +: PIX_W];
                    tap_reg[ch][r*3+2] <= newcol[2-r][ch*PIX_W +: PIX_W];
                end
            end
        end
        if (merge) begin
            for (int ch = 0; ch < N_CH; ch++) begin
                mag_reg[ch] <= sat8(lane_root[ch]);
            end
            m_fend_reg <= fend_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_mag   = mag_reg[0];
    assign m_green_mag = mag_reg[1];
    assign m_blue_mag  = mag_reg[2];
    assign m_frame_end = m_fend_reg;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == ST_LOAD))
        else $error("accepted pixel did not enter load");

    a_start_idle_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctl.start |-> (lane_busy == '0))
        else $error("lane started while busy");

    a_out_from_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_CALC))
        else $error("result appeared without a finished calculation");

endmodule
